// ===== sv/bfd_pkg.sv =====
`default_nettype none
package bfd_pkg;
	localparam int MAX_GRID_D    = 256;
	localparam int MAX_SRC_DIM_D = 4096;
	localparam int SAMPLE_BITS_D = 16;
	localparam int CFG_W         = 13;
	localparam int IDX_W         = 2;
	localparam int SUM_W         = 40;
	localparam int AREA_W        = 25;

	typedef enum logic [IDX_W-1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_OUT_SIZE   = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

	// Request from the accumulator to the mean divider
	typedef struct packed {
		logic              vld;
		logic              bad;
		logic [SUM_W-1:0]  sum;
		logic [AREA_W-1:0] area;
		logic [7:0]        gx;
		logic [7:0]        gy;
		logic              last;
	} div_req_t;
endpackage
`default_nettype wire

// ===== sv/box_filter_downsampler_unit.sv =====
`default_nettype none
// Box-filter downsampler. Source samples enter in raster order; each tile of
// (src_width/out_size) x (src_height/out_size) samples is summed in a 256-entry
// synchronous accumulator memory (read, then add and write back in the cycle
// after) and its truncated mean leaves with grid coordinates after the tile's
// last sample. Each sample passes memory read, write back and a turnaround
// state before the next sample is taken; a tile's last sample also runs the
// 40-step serial mean divider, which must finish before the next sample is
// taken. A finished mean waits in an output register, so a stalled receiver
// holds the input only once a second mean is ready behind it. After reset and
// after every configuration write the tile size is recomputed by two serial
// divisions, during which no sample is taken. A zero tile size answers each
// sample with a bad_size result.
// Write configuration only when idle.
module box_filter_downsampler_unit import bfd_pkg::*; #(
	parameter int MAX_GRID    = MAX_GRID_D
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [IDX_W-1:0]         cfg_idx,
	input  wire logic [CFG_W-1:0]         cfg_wdata,
	input  wire logic                     sample_valid,
	output logic                          sample_ready,
	input  wire logic [SAMPLE_BITS_D-1:0] sample,
	output logic                          result_valid,
	input  wire logic                     result_ready,
	output logic [SAMPLE_BITS_D-1:0]      mean,
	output logic [7:0]                    grid_x,
	output logic [7:0]                    grid_y,
	output logic                          last,
	output logic                          bad_size
);
	localparam int SLOT_W = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;

	typedef enum logic [3:0] {
		ST_SIZE = 4'b0001, // tile size being derived
		ST_IDLE = 4'b0010, // wait for a sample
		ST_RMW  = 4'b0100, // memory read done, write back
		ST_WAIT = 4'b1000  // turnaround before the next sample
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  w_q, h_q, n_q;
	logic [CFG_W-1:0]  wc, hc, nc;
	logic [CFG_W-1:0]  tw_q, th_q;
	logic [CFG_W-1:0]  col_q, row_q;   // position in frame
	logic [CFG_W-1:0]  ox_q, oy_q;     // offset within tile
	logic [CFG_W-1:0]  gx_q, gy_q;     // tile coordinates
	logic [CFG_W-1:0]  gx_s1, gy_s1;   // tile of the sample in write back
	logic [1:0]        phase_q;        // 0: width, 1: height
	logic              tstart;
	logic              tbusy, tbusy_q;
	logic [CFG_W-1:0]  tnum, tquo;
	logic [SUM_W-1:0]  mem [MAX_GRID];
	logic [SUM_W-1:0]  rd_s1;
	logic [SAMPLE_BITS_D-1:0] smp_s1;
	logic              first_s1, end_s1, inside_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [SUM_W-1:0]  nsum;
	logic              take, dbusy;
	div_req_t          req;

	// Clamp oversized registers
	assign wc = (w_q > CFG_W'(MAX_SRC_DIM_D)) ? CFG_W'(MAX_SRC_DIM_D) : w_q;
	assign hc = (h_q > CFG_W'(MAX_SRC_DIM_D)) ? CFG_W'(MAX_SRC_DIM_D) : h_q;
	assign nc = (n_q > CFG_W'(MAX_GRID)) ? CFG_W'(MAX_GRID) : n_q;

	assign tnum = (phase_q == 2'd0) ? wc : hc;
	assign sample_ready = (state_q == ST_IDLE) && !dbusy;
	assign take = sample_valid && sample_ready;

	bfd_tdiv u_tdiv (
		.clk, .arst_n, .start(tstart), .num(tnum), .den(nc),
		.busy(tbusy), .quo(tquo)
	);

	// Accumulate: restart on a tile's first sample
	assign nsum = (first_s1 ? '0 : rd_s1) + SUM_W'(smp_s1);

	always_comb begin
		req      = '0;
		req.vld  = 1'b0;
		req.sum  = nsum;
		req.area = AREA_W'(tw_q) * AREA_W'(th_q);
		req.gx   = gx_s1[7:0];
		req.gy   = gy_s1[7:0];
		req.last = (gx_s1 == nc - 1'b1) && (gy_s1 == nc - 1'b1);
		if (take && (tw_q == '0 || th_q == '0)) begin
			req.vld = 1'b1;
			req.bad = 1'b1;
		end else if (state_q == ST_RMW && inside_s1 && end_s1) begin
			req.vld = 1'b1;
		end
	end

	bfd_div #(.SAMPLE_BITS(SAMPLE_BITS_D)) u_div (
		.clk, .arst_n, .req, .busy(dbusy), .valid(result_valid),
		.ready(result_ready), .mean, .grid_x, .grid_y, .last, .bad_size
	);

	always_ff @(posedge clk) begin
		if (take) rd_s1 <= mem[gx_q[SLOT_W-1:0]];
		if (state_q == ST_RMW && inside_s1) mem[slot_s1] <= nsum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SIZE;
			w_q <= CFG_W'(256);
			h_q <= CFG_W'(256);
			n_q <= CFG_W'(16);
			phase_q <= 2'd0;
			tstart <= 1'b1;
			tbusy_q <= 1'b0;
			tw_q <= '0; th_q <= '0;
			col_q <= '0; row_q <= '0; ox_q <= '0; oy_q <= '0;
			gx_q <= '0; gy_q <= '0;
			gx_s1 <= '0; gy_s1 <= '0;
			smp_s1 <= '0; first_s1 <= 1'b0; end_s1 <= 1'b0;
			inside_s1 <= 1'b0; slot_s1 <= '0;
		end else begin
			tstart  <= 1'b0;
			tbusy_q <= tbusy;
			if (cfg_we && cfg_idx != REG_NONE) begin
				unique case (cfg_idx)
					REG_SRC_WIDTH:  w_q <= cfg_wdata;
					REG_SRC_HEIGHT: h_q <= cfg_wdata;
					REG_OUT_SIZE:   n_q <= {4'd0, cfg_wdata[8:0]};
					default:        ;
				endcase
				state_q <= ST_SIZE;
				phase_q <= 2'd0;
				tstart  <= 1'b1;
			end else begin
				unique case (state_q)
					ST_SIZE: begin
						// zero divisor gives all ones; forced to zero below
						if (tbusy_q && !tbusy && !tstart) begin
							if (phase_q == 2'd0) begin
								tw_q <= (nc == '0) ? '0 : tquo;
								phase_q <= 2'd1;
								tstart  <= 1'b1;
							end else begin
								th_q <= (nc == '0) ? '0 : tquo;
								col_q <= '0; row_q <= '0; ox_q <= '0; oy_q <= '0;
								gx_q <= '0; gy_q <= '0;
								state_q <= ST_IDLE;
							end
						end
					end
					ST_IDLE: begin
						if (take && tw_q != '0 && th_q != '0) begin
							smp_s1    <= sample;
							slot_s1   <= gx_q[SLOT_W-1:0];
							gx_s1     <= gx_q;
							gy_s1     <= gy_q;
							first_s1  <= (ox_q == '0) && (oy_q == '0);
							end_s1    <= (ox_q == tw_q - 1'b1) && (oy_q == th_q - 1'b1);
							inside_s1 <= (gx_q < nc) && (gy_q < nc);
							state_q   <= ST_RMW;
							// advance position
							if (col_q + 1'b1 >= wc) begin
								col_q <= '0; ox_q <= '0; gx_q <= '0;
								if (row_q + 1'b1 >= hc) begin
									row_q <= '0; oy_q <= '0; gy_q <= '0;
								end else begin
									row_q <= row_q + 1'b1;
									if (oy_q == th_q - 1'b1) begin
										oy_q <= '0; gy_q <= gy_q + 1'b1;
									end else begin
										oy_q <= oy_q + 1'b1;
									end
								end
							end else begin
								col_q <= col_q + 1'b1;
								if (ox_q == tw_q - 1'b1) begin
									ox_q <= '0; gx_q <= gx_q + 1'b1;
								end else begin
									ox_q <= ox_q + 1'b1;
								end
							end
						end
					end
					ST_RMW:  state_q <= ST_WAIT;
					ST_WAIT: state_q <= ST_IDLE;
					default: state_q <= ST_SIZE;
				endcase
			end
		end
	end

`ifndef SYNTH
	a_no_take_in_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !sample_ready) else $error("sample taken while busy");
	a_rmw_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(take && tw_q != '0 && th_q != '0 && !cfg_we) |=> state_q == ST_RMW)
		else $error("accepted sample not written back");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && bad_size) |-> (grid_x == 8'd0 && grid_y == 8'd0 && !last))
		else $error("bad_size result carries coordinates");
`endif
endmodule
`default_nettype wire

// ===== sv/bfd_div.sv =====
`default_nettype none
module bfd_div import bfd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_D
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  div_req_t                    req,
	output logic                        busy,
	output logic                        valid,
	input  wire logic                   ready,
	output logic [SAMPLE_BITS-1:0]      mean,
	output logic [7:0]                  grid_x,
	output logic [7:0]                  grid_y,
	output logic                        last,
	output logic                        bad_size
);
	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [AREA_W-1:0] den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic              bad_q;
	logic              last_q;
	logic [7:0]        gx_q;
	logic [7:0]        gy_q;
	logic              free;
	logic [SUM_W:0]    trial;
	logic [SUM_W:0]    shifted;

	// Restoring division, one quotient bit per cycle, MSB first
	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign trial   = shifted - {{(SUM_W+1-AREA_W){1'b0}}, den_q};
	// Output register can take a finished result this cycle
	assign free    = !valid || ready;
	assign busy    = run_q || done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			valid  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (done_q && free) begin
				valid  <= 1'b1;
				done_q <= 1'b0;
			end else if (valid && ready) begin
				valid <= 1'b0;
			end
			if (req.vld) begin
				if (req.bad) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
					cnt_q <= CNT_W'(SUM_W);
				end
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.vld) begin
			rem_q  <= '0;
			quo_q  <= req.sum;
			den_q  <= req.area;
			gx_q   <= req.bad ? 8'd0 : req.gx;
			gy_q   <= req.bad ? 8'd0 : req.gy;
			last_q <= req.bad ? 1'b0 : req.last;
			bad_q  <= req.bad;
		end else if (run_q) begin
			if (!trial[SUM_W]) begin
				rem_q <= trial[SUM_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[SUM_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
		if (done_q && free) begin
			mean     <= bad_q ? '0 : quo_q[SAMPLE_BITS-1:0];
			grid_x   <= gx_q;
			grid_y   <= gy_q;
			last     <= last_q;
			bad_size <= bad_q;
		end
	end

`ifndef SYNTH
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !req.vld) else $error("divider request while busy");
	a_cnt_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> cnt_q != '0) else $error("divider count lost");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(run_q) |-> done_q) else $error("divider finished without result");
`endif
endmodule
`default_nettype wire

// ===== sv/bfd_tdiv.sv =====
`default_nettype none
module bfd_tdiv import bfd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [CFG_W-1:0]  num,
	input  wire logic [CFG_W-1:0]  den,
	output logic                   busy,
	output logic [CFG_W-1:0]       quo
);
	// Tile size: num / den, one bit per cycle
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] q_q;
	logic [CFG_W-1:0] den_q;
	logic [3:0]       cnt_q;
	logic [CFG_W:0]   sh;
	logic [CFG_W:0]   tr;

	assign sh = {rem_q, q_q[CFG_W-1]};
	assign tr = sh - {1'b0, den_q};
	assign busy = cnt_q != '0;
	assign quo = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 4'(CFG_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= num;
			den_q <= den;
		end else if (busy) begin
			if (!tr[CFG_W]) begin
				rem_q <= tr[CFG_W-1:0];
				q_q   <= {q_q[CFG_W-2:0], 1'b1};
			end else begin
				rem_q <= sh[CFG_W-1:0];
				q_q   <= {q_q[CFG_W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire
